### hw/rtl/mrfp_pkg.sv
`default_nettype none
package mrfp_pkg;

	localparam int PAYLOAD_BYTES = 64;
	localparam int CHANNEL_COUNT = 16;

	localparam int ADDR_W = $clog2(PAYLOAD_BYTES);
	// channel counter is at least as wide as the 4-bit index field
	localparam int IDX_W = ($clog2(CHANNEL_COUNT) > 4) ? $clog2(CHANNEL_COUNT) : 4;
	localparam int POS_W = IDX_W + 1;

	localparam int RUNQ_DEPTH = 2;
	localparam int RUNQ_CNT_W = $clog2(RUNQ_DEPTH + 1);

	localparam logic [7:0] SYNC_DOLLAR     = 8'h24;
	localparam logic [7:0] SYNC_EM         = 8'h4D;
	localparam logic [7:0] SYNC_GT         = 8'h3E;
	localparam logic [7:0] DEFAULT_COMMAND = 8'd105;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_SYNC_M  = 3'd1,
		PH_SYNC_GT = 3'd2,
		PH_LEN     = 3'd3,
		PH_CMD     = 3'd4,
		PH_PAYLOAD = 3'd5,
		PH_CHECK   = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_RD_LO,
		BK_RD_HI,
		BK_CAPTURE,
		BK_OUT
	} back_state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} store_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} store_rd_t;

	typedef struct packed {
		logic nonempty;
		logic full;
	} runq_status_t;

endpackage
`default_nettype wire

### hw/rtl/mrfp_if.sv
`default_nettype none
interface mrfp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface mrfp_chan_if;
	logic        valid;
	logic        ready;
	logic [3:0]  channel_index;
	logic [15:0] channel_value;
	logic        last_channel;
	modport source (output valid, output channel_index, output channel_value,
		output last_channel, input ready);
	modport sink (input valid, input channel_index, input channel_value,
		input last_channel, output ready);
endinterface

interface mrfp_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] accepted_command;
	modport source (output valid, output accepted_command, input ready);
	modport sink (input valid, input accepted_command, output ready);
endinterface
`default_nettype wire

### hw/rtl/mrfp_ram.sv
`default_nettype none
module mrfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### hw/rtl/mrfp_store.sv
`default_nettype none
module mrfp_store
	import mrfp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire store_wr_t wr,
	input  wire store_rd_t rd,
	output logic [7:0]     rd_data
);

	logic [PAYLOAD_BYTES-1:0] valid_q;
	logic                     vld_rd_s1;
	logic [7:0]               ram_rdata;

	mrfp_ram #(
		.WIDTH(8),
		.DEPTH(PAYLOAD_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd.en),
		.raddr (rd.addr),
		.rdata (ram_rdata)
	);

	// entries never written since reset read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			vld_rd_s1 <= 1'b0;
		end else begin
			if (wr.we) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				vld_rd_s1 <= valid_q[rd.addr];
			end
		end
	end

	assign rd_data = vld_rd_s1 ? ram_rdata : 8'd0;

endmodule
`default_nettype wire

### hw/rtl/mrfp_runq.sv
`default_nettype none
module mrfp_runq
	import mrfp_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire logic   pop,
	output runq_status_t status
);

	logic [RUNQ_CNT_W-1:0] cnt_q;

	// token queue of pending channel runs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + RUNQ_CNT_W'(1);
		end else if (pop && !push) begin
			cnt_q <= cnt_q - RUNQ_CNT_W'(1);
		end
	end

	assign status.nonempty = (cnt_q != '0);
	assign status.full     = (cnt_q == RUNQ_CNT_W'(RUNQ_DEPTH));

endmodule
`default_nettype wire

### hw/rtl/mrfp_front.sv
`default_nettype none
module mrfp_front
	import mrfp_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	mrfp_rx_if.sink     rx,
	mrfp_cfg_if.sink    cfg,
	input  wire runq_status_t q_stat,
	input  wire logic   back_busy,
	output store_wr_t   wr,
	output logic        push
);

	phase_t     phase_q, phase_d;
	logic [7:0] len_q;
	logic [7:0] cmd_q;
	logic [7:0] cnt_q;
	logic [7:0] xor_q;
	logic [7:0] acc_q;
	logic [7:0] cnt_inc;
	logic       xfer;
	logic [7:0] b;

	assign b       = rx.rx_byte;
	assign xfer    = rx.valid && rx.ready;
	assign cnt_inc = cnt_q + 8'd1;
	assign cfg.ready = 1'b1;

	always_comb begin
		phase_d = phase_q;
		if (xfer) begin
			unique case (phase_q)
				PH_IDLE:    phase_d = (b == SYNC_DOLLAR) ? PH_SYNC_M : PH_IDLE;
				PH_SYNC_M:  phase_d = (b == SYNC_EM) ? PH_SYNC_GT : PH_IDLE;
				PH_SYNC_GT: phase_d = (b == SYNC_GT) ? PH_LEN : PH_IDLE;
				PH_LEN:     phase_d = PH_CMD;
				PH_CMD:     phase_d = (len_q != 8'd0) ? PH_PAYLOAD : PH_CHECK;
				PH_PAYLOAD: phase_d = (cnt_inc >= len_q) ? PH_CHECK : PH_PAYLOAD;
				PH_CHECK:   phase_d = PH_IDLE;
				default:    phase_d = PH_IDLE;
			endcase
		end
	end

	always_comb begin
		// payload writes wait until the back end has finished reading the store
		rx.ready = 1'b1;
		wr.we    = 1'b0;
		wr.addr  = ADDR_W'(cnt_q);
		wr.data  = b;
		push     = 1'b0;
		unique case (phase_q)
			PH_PAYLOAD: begin
				rx.ready = !(q_stat.nonempty || back_busy);
				wr.we    = xfer && ({1'b0, cnt_q} < 9'(PAYLOAD_BYTES));
			end
			PH_CHECK: begin
				rx.ready = !q_stat.full;
				push     = xfer && (xor_q == b) && (cmd_q == acc_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			len_q   <= 8'd0;
			cmd_q   <= 8'd0;
			cnt_q   <= 8'd0;
			xor_q   <= 8'd0;
			acc_q   <= DEFAULT_COMMAND;
		end else begin
			phase_q <= phase_d;
			if (cfg.valid) begin
				acc_q <= cfg.accepted_command;
			end
			if (xfer) begin
				case (phase_q)
					PH_LEN: begin
						len_q <= b;
						xor_q <= b;
					end
					PH_CMD: begin
						cmd_q <= b;
						xor_q <= xor_q ^ b;
						cnt_q <= 8'd0;
					end
					PH_PAYLOAD: begin
						xor_q <= xor_q ^ b;
						cnt_q <= cnt_inc;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/mrfp_back.sv
`default_nettype none
module mrfp_back
	import mrfp_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire runq_status_t q_stat,
	output logic         pop,
	output logic         busy,
	output store_rd_t    rd,
	input  wire logic [7:0] rd_data,
	mrfp_chan_if.source  chan
);

	back_state_t       state_q, state_d;
	logic [IDX_W-1:0]  ch_q;
	logic [7:0]        lo_q;
	logic [15:0]       value_q;
	logic              oob_s1;
	logic [POS_W-1:0]  pos_lo;
	logic [POS_W-1:0]  pos_hi;
	logic [POS_W-1:0]  pos;
	logic              pos_oob;
	logic [7:0]        byte_in;
	logic              last;

	assign pos_lo  = {ch_q, 1'b0};
	assign pos_hi  = {ch_q, 1'b1};
	assign pos     = (state_q == BK_RD_HI) ? pos_hi : pos_lo;
	assign pos_oob = (int'(pos) >= PAYLOAD_BYTES);
	assign byte_in = oob_s1 ? 8'd0 : rd_data;
	assign last    = (ch_q == IDX_W'(CHANNEL_COUNT - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:    if (q_stat.nonempty) state_d = BK_RD_LO;
			BK_RD_LO:   state_d = BK_RD_HI;
			BK_RD_HI:   state_d = BK_CAPTURE;
			BK_CAPTURE: state_d = BK_OUT;
			BK_OUT:     if (chan.ready) state_d = last ? BK_IDLE : BK_RD_LO;
			default:    state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop     = (state_q == BK_IDLE) && q_stat.nonempty;
		busy    = (state_q != BK_IDLE);
		rd.en   = (state_q == BK_RD_LO) || (state_q == BK_RD_HI);
		rd.addr = ADDR_W'(pos);
		chan.valid         = (state_q == BK_OUT);
		chan.channel_index = ch_q[3:0];
		chan.channel_value = value_q;
		chan.last_channel  = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			ch_q    <= '0;
			oob_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rd.en) begin
				oob_s1 <= pos_oob;
			end
			if (pop) begin
				ch_q <= '0;
			end else if ((state_q == BK_OUT) && chan.ready && !last) begin
				ch_q <= ch_q + IDX_W'(1);
			end
		end
	end

	// read data is registered and arrives in the cycle after each address
	always_ff @(posedge clk) begin
		if (state_q == BK_RD_HI) begin
			lo_q <= byte_in;
		end
		if (state_q == BK_CAPTURE) begin
			value_q <= {byte_in, lo_q};
		end
	end

endmodule
`default_nettype wire

### hw/rtl/msp_rc_frame_parser_core.sv
// Response frame parser: one received byte per cycle while no channel run is pending.
// A matching checksum byte with the accepted command queues a run; the back end pops it when idle.
// Each channel passes through two store reads, a capture and the output register, which waits for ready.
// Payload bytes stall while a run is queued or being read out; a checksum byte
// stalls only while two runs are queued.
// Reset (arst_n low, asynchronous): parser idle, command register 105, store reads zero.
`default_nettype none
module msp_rc_frame_parser_core
	import mrfp_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	mrfp_rx_if.sink      rx,
	mrfp_cfg_if.sink     cfg,
	mrfp_chan_if.source  chan
);

	runq_status_t q_stat;
	store_wr_t    wr;
	store_rd_t    rd;
	logic [7:0]   rd_data;
	logic         push;
	logic         pop;
	logic         back_busy;

	mrfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.cfg       (cfg),
		.q_stat    (q_stat),
		.back_busy (back_busy),
		.wr        (wr),
		.push      (push)
	);

	mrfp_runq u_runq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.status (q_stat)
	);

	mrfp_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	mrfp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_stat  (q_stat),
		.pop     (pop),
		.busy    (back_busy),
		.rd      (rd),
		.rd_data (rd_data),
		.chan    (chan)
	);

endmodule
`default_nettype wire
